// ===== rtl/gravity_body_integrator_unit_assert.svh =====
// Assertion macros for the gravity body integrator.
// Needs clk and arst_n in the scope where the macros are used.
`ifndef GRAVITY_BODY_INTEGRATOR_UNIT_ASSERT_SVH
`define GRAVITY_BODY_INTEGRATOR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define GBI_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gbi assertion failed");

// Next-cycle implication.
`define GBI_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gbi assertion failed");

`endif

// ===== rtl/gbi_pkg.sv =====
// Shared types, codes and helpers for the gravity body integrator.
// No dependencies.
package gbi_pkg;

	typedef enum logic [1:0] {
		REQ_INTERACT = 2'd0,
		REQ_TICK     = 2'd1,
		REQ_CLEAR    = 2'd2,
		REQ_NOP      = 2'd3
	} req_t;

	localparam logic [1:0] CFG_MASS = 2'd0;
	localparam logic [1:0] CFG_SPIN = 2'd1;

	// 0.1 in Q16.16
	localparam logic [12:0] TENTH_Q16 = 13'd6554;
	localparam logic [31:0] SAT_MAX   = 32'h7FFF_FFFF;
	localparam logic [31:0] SAT_MIN   = 32'h8000_0000;
	localparam logic [31:0] MASS_RST  = 32'd6553600;

	typedef enum logic {
		OP_DIV  = 1'b0,
		OP_SQRT = 1'b1
	} unit_op_t;

	typedef struct packed {
		logic         start;
		unit_op_t     op;
		logic [63:0]  opnd;     // radicand, or initial remainder for divide
		logic [30:0]  low;      // numerator bits shifted in by divide
		logic [63:0]  divisor;
	} unit_req_t;

	typedef struct packed {
		logic         busy;
		logic         done;
		logic         sat;      // quotient would need 32 bits or more
		logic [31:0]  result;
	} unit_rsp_t;

	// Clamp a signed 34-bit value to signed 32 bits.
	function automatic logic [31:0] sat32(input logic [33:0] v);
		logic [31:0] r;
		if (!v[33] && (v[32:31] != 2'b00)) begin
			r = SAT_MAX;
		end else if (v[33] && (v[32:31] != 2'b11)) begin
			r = SAT_MIN;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/gbi_iter_unit.sv =====
// Shared iterative unit: restoring square root (two bits a step) and
// restoring divide with 31 quotient bits. Depends on gbi_pkg.
module gbi_iter_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  gbi_pkg::unit_req_t req,
	output gbi_pkg::unit_rsp_t rsp
);
	import gbi_pkg::*;

	logic [65:0] rem_q;
	logic [63:0] src_q;
	logic [63:0] div_q;
	logic [31:0] quo_q;
	logic [5:0]  cnt_q;
	logic        busy_q, done_q, chk_q, sat_q;
	unit_op_t    op_q;

	logic [65:0] opa, opb;
	logic [66:0] diff;
	logic        ge;

	// Select operands for the one subtractor
	always_comb begin
		opa = '0;
		opb = '0;
		if (op_q == OP_SQRT) begin
			opa = {rem_q[63:0], src_q[63:62]};
			opb = {32'b0, quo_q, 2'b01};
		end else if (chk_q) begin
			opa = rem_q;
			opb = {2'b0, div_q};
		end else begin
			opa = {rem_q[64:0], src_q[30]};
			opb = {2'b0, div_q};
		end
		diff = {1'b0, opa} - {1'b0, opb};
		ge   = !diff[66];
	end

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			chk_q  <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			chk_q  <= (req.op == OP_DIV);
			cnt_q  <= (req.op == OP_SQRT) ? 6'd32 : 6'd31;
		end else if (busy_q) begin
			done_q <= 1'b0;
			if (chk_q) begin
				chk_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Datapath: load, then one digit a cycle (a divide first checks for overflow)
	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q  <= req.op;
			div_q <= req.divisor;
			quo_q <= '0;
			sat_q <= 1'b0;
			if (req.op == OP_SQRT) begin
				rem_q <= '0;
				src_q <= req.opnd;
			end else begin
				rem_q <= {2'b0, req.opnd};
				src_q <= {33'b0, req.low};
			end
		end else if (busy_q) begin
			if (op_q == OP_SQRT) begin
				rem_q <= ge ? diff[65:0] : opa;
				quo_q <= {quo_q[30:0], ge};
				src_q <= {src_q[61:0], 2'b00};
			end else if (chk_q) begin
				sat_q <= ge;
			end else begin
				rem_q <= ge ? diff[65:0] : opa;
				quo_q <= {quo_q[30:0], ge};
				src_q <= {src_q[62:0], 1'b0};
			end
		end
	end

	assign rsp.busy   = busy_q;
	assign rsp.done   = done_q;
	assign rsp.sat    = sat_q;
	assign rsp.result = quo_q;

endmodule

// ===== rtl/gravity_body_integrator_unit.sv =====
// Interact: a square root then three divides on the shared unit before the result goes to the
// output register; at zero distance these are skipped. Tick: two divides of force by mass.
// Clear and no-op go straight to the output register.
// One word in work at a time; the next is taken the cycle after the result is loaded.
// Reset clears position, velocity, force, heading and spin rate, and loads mass 100.0.
// Depends on gbi_pkg, gbi_iter_unit and gravity_body_integrator_unit_assert.svh.
`include "gravity_body_integrator_unit_assert.svh"

module gravity_body_integrator_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic signed [31:0] other_pos_x,
	input  logic signed [31:0] other_pos_y,
	input  logic [31:0] other_mass,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [31:0] out_pos_x,
	output logic signed [31:0] out_pos_y,
	output logic signed [31:0] out_vel_x,
	output logic signed [31:0] out_vel_y,
	output logic [15:0] out_heading
);
	import gbi_pkg::*;

	typedef enum logic [18:0] {
		ST_IDLE   = 19'h00001,
		ST_DIFF   = 19'h00002,
		ST_ABS    = 19'h00004,
		ST_SQX    = 19'h00008,
		ST_SQY    = 19'h00010,
		ST_GMUL   = 19'h00020,
		ST_AMUL   = 19'h00040,
		ST_SQRT   = 19'h00080,
		ST_DIVF   = 19'h00100,
		ST_DIVX   = 19'h00200,
		ST_DIVY   = 19'h00400,
		ST_MX     = 19'h00800,
		ST_MY     = 19'h01000,
		ST_FAPPLY = 19'h02000,
		ST_TGO    = 19'h04000,
		ST_TWX    = 19'h08000,
		ST_TWY    = 19'h10000,
		ST_TAPPLY = 19'h20000,
		ST_DONE   = 19'h40000
	} state_t;

	state_t state_q;

	// Architectural state
	logic [31:0] mass_q;
	logic [15:0] spin_q;
	logic [31:0] pos_x_q, pos_y_q, vel_x_q, vel_y_q, fs_x_q, fs_y_q;
	logic [15:0] head_q;

	// Working registers
	logic [31:0] ox_q, oy_q, om_q;
	logic [32:0] dx_q, dy_q;
	logic [30:0] ux_q, uy_q;
	logic        k_q, sgx_q, sgy_q;
	logic [61:0] sx_q;
	logic [63:0] s_q;
	logic [47:0] g_q;
	logic [60:0] a_q;
	logic [31:0] d_q;
	logic [30:0] f_q, nx_q, ny_q;
	logic [31:0] mx_q, my_q, accx_q, accy_q;

	// Output register
	logic        out_valid_q;
	logic [31:0] opx_q, opy_q, ovx_q, ovy_q;
	logic [15:0] ohd_q;

	unit_req_t unit_req;
	unit_rsp_t unit_rsp;

	logic [32:0] ax, ay;
	logic [31:0] magx, magy;
	logic [31:0] acc_new;
	logic [31:0] velx_new, vely_new;
	logic [60:0] a_full;
	logic        out_load;
	logic        unit_wait;

	gbi_iter_unit u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (unit_req),
		.rsp    (unit_rsp)
	);

	assign in_ready = (state_q == ST_IDLE);
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// States that wait on the shared unit
	assign unit_wait = (state_q == ST_SQRT) || (state_q == ST_DIVF) || (state_q == ST_DIVX)
		|| (state_q == ST_DIVY) || (state_q == ST_TWX) || (state_q == ST_TWY);

	// Magnitudes of separation and force, and g times 0.1
	always_comb begin
		ax   = dx_q[32] ? (33'd0 - dx_q) : dx_q;
		ay   = dy_q[32] ? (33'd0 - dy_q) : dy_q;
		magx = fs_x_q[31] ? (32'd0 - fs_x_q) : fs_x_q;
		magy = fs_y_q[31] ? (32'd0 - fs_y_q) : fs_y_q;
		a_full = 61'(g_q) * 61'(TENTH_Q16);
	end

	// Acceleration from the divide just finished (axis from state)
	always_comb begin
		logic neg;
		neg = (state_q == ST_TWX) ? fs_x_q[31] : fs_y_q[31];
		if (mass_q == 32'd0) begin
			acc_new = '0;
		end else if (unit_rsp.sat) begin
			acc_new = neg ? SAT_MIN : SAT_MAX;
		end else if (neg) begin
			acc_new = 32'd0 - {1'b0, unit_rsp.result[30:0]};
		end else begin
			acc_new = {1'b0, unit_rsp.result[30:0]};
		end
	end

	// Issue work to the shared unit
	always_comb begin
		unit_req = '0;
		unit_req.op = OP_DIV;
		case (state_q)
			ST_AMUL: begin
				unit_req.start = 1'b1;
				unit_req.op    = OP_SQRT;
				unit_req.opnd  = s_q;
			end
			ST_SQRT: begin
				unit_req.start   = unit_rsp.done;
				unit_req.opnd    = {18'b0, a_q[60:15]};
				unit_req.low     = {a_q[14:0], 16'b0};
				unit_req.divisor = s_q;
			end
			ST_DIVF: begin
				unit_req.start   = unit_rsp.done;
				unit_req.opnd    = {34'b0, ux_q[30:1]};
				unit_req.low     = {ux_q[0], 30'b0};
				unit_req.divisor = {32'b0, d_q};
			end
			ST_DIVX: begin
				unit_req.start   = unit_rsp.done;
				unit_req.opnd    = {34'b0, uy_q[30:1]};
				unit_req.low     = {uy_q[0], 30'b0};
				unit_req.divisor = {32'b0, d_q};
			end
			ST_TGO: begin
				unit_req.start   = 1'b1;
				unit_req.opnd    = {47'b0, magx[31:15]};
				unit_req.low     = {magx[14:0], 16'b0};
				unit_req.divisor = {32'b0, mass_q};
			end
			ST_TWX: begin
				unit_req.start   = unit_rsp.done;
				unit_req.opnd    = {47'b0, magy[31:15]};
				unit_req.low     = {magy[14:0], 16'b0};
				unit_req.divisor = {32'b0, mass_q};
			end
			default: begin
				unit_req.start = 1'b0;
			end
		endcase
	end

	always_comb begin
		velx_new = sat32({{2{vel_x_q[31]}}, vel_x_q} + {{2{accx_q[31]}}, accx_q});
		vely_new = sat32({{2{vel_y_q[31]}}, vel_y_q} + {{2{accy_q[31]}}, accy_q});
	end

	// Sequencer and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mass_q  <= MASS_RST;
			spin_q  <= '0;
			pos_x_q <= '0;
			pos_y_q <= '0;
			vel_x_q <= '0;
			vel_y_q <= '0;
			fs_x_q  <= '0;
			fs_y_q  <= '0;
			head_q  <= '0;
		end else begin
			// take configuration words
			if (cfg_we && (cfg_idx == CFG_MASS)) begin
				mass_q <= cfg_data;
			end else if (cfg_we && (cfg_idx == CFG_SPIN)) begin
				spin_q <= cfg_data[15:0];
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						case (req_t'(req_type))
							REQ_INTERACT: state_q <= ST_DIFF;
							REQ_TICK:     state_q <= ST_TGO;
							REQ_CLEAR: begin
								pos_x_q <= '0;
								pos_y_q <= '0;
								vel_x_q <= '0;
								vel_y_q <= '0;
								head_q  <= '0;
								spin_q  <= '0;
								state_q <= ST_DONE;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_DIFF: state_q <= ST_ABS;
				ST_ABS: begin
					if ((dx_q == 33'd0) && (dy_q == 33'd0)) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_SQX;
					end
				end
				ST_SQX:  state_q <= ST_SQY;
				ST_SQY:  state_q <= ST_GMUL;
				ST_GMUL: state_q <= ST_AMUL;
				ST_AMUL: state_q <= ST_SQRT;
				ST_SQRT: if (unit_rsp.done) state_q <= ST_DIVF;
				ST_DIVF: if (unit_rsp.done) state_q <= ST_DIVX;
				ST_DIVX: if (unit_rsp.done) state_q <= ST_DIVY;
				ST_DIVY: if (unit_rsp.done) state_q <= ST_MX;
				ST_MX:   state_q <= ST_MY;
				ST_MY:   state_q <= ST_FAPPLY;
				ST_FAPPLY: begin
					fs_x_q  <= sat32(sgx_q ? ({{2{fs_x_q[31]}}, fs_x_q} - {2'b0, mx_q})
					                       : ({{2{fs_x_q[31]}}, fs_x_q} + {2'b0, mx_q}));
					fs_y_q  <= sat32(sgy_q ? ({{2{fs_y_q[31]}}, fs_y_q} - {2'b0, my_q})
					                       : ({{2{fs_y_q[31]}}, fs_y_q} + {2'b0, my_q}));
					state_q <= ST_DONE;
				end
				ST_TGO: state_q <= ST_TWX;
				ST_TWX: if (unit_rsp.done) state_q <= ST_TWY;
				ST_TWY: if (unit_rsp.done) state_q <= ST_TAPPLY;
				ST_TAPPLY: begin
					vel_x_q <= velx_new;
					vel_y_q <= vely_new;
					pos_x_q <= sat32({{2{pos_x_q[31]}}, pos_x_q} + {{2{velx_new[31]}}, velx_new});
					pos_y_q <= sat32({{2{pos_y_q[31]}}, pos_y_q} + {{2{vely_new[31]}}, vely_new});
					fs_x_q  <= '0;
					fs_y_q  <= '0;
					head_q  <= head_q + spin_q;
					state_q <= ST_DONE;
				end
				ST_DONE: if (out_load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Working datapath registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ox_q <= other_pos_x;
			oy_q <= other_pos_y;
			om_q <= other_mass;
		end
		case (state_q)
			ST_DIFF: begin
				dx_q <= {pos_x_q[31], pos_x_q} - {ox_q[31], ox_q};
				dy_q <= {pos_y_q[31], pos_y_q} - {oy_q[31], oy_q};
			end
			ST_ABS: begin
				// halve both when either would not fit 31 bits
				k_q   <= ax[31] | ay[31];
				ux_q  <= (ax[31] | ay[31]) ? ax[31:1] : ax[30:0];
				uy_q  <= (ax[31] | ay[31]) ? ay[31:1] : ay[30:0];
				sgx_q <= !dx_q[32] && (dx_q != 33'd0);
				sgy_q <= !dy_q[32] && (dy_q != 33'd0);
			end
			ST_SQX:  sx_q <= 62'(ux_q) * 62'(ux_q);
			ST_SQY:  s_q  <= 64'(sx_q) + 64'(62'(uy_q) * 62'(uy_q));
			ST_GMUL: g_q  <= 48'((64'(mass_q) * 64'(om_q)) >> 16);
			ST_AMUL: a_q  <= k_q ? (a_full >> 2) : a_full;
			ST_SQRT: if (unit_rsp.done) d_q <= unit_rsp.result;
			ST_DIVF: if (unit_rsp.done) f_q <= unit_rsp.sat ? '1 : unit_rsp.result[30:0];
			ST_DIVX: if (unit_rsp.done) nx_q <= unit_rsp.result[30:0];
			ST_DIVY: if (unit_rsp.done) ny_q <= unit_rsp.result[30:0];
			ST_MX:   mx_q <= 32'((62'(f_q) * 62'(nx_q)) >> 30);
			ST_MY:   my_q <= 32'((62'(f_q) * 62'(ny_q)) >> 30);
			ST_TWX:  if (unit_rsp.done) accx_q <= acc_new;
			ST_TWY:  if (unit_rsp.done) accy_q <= acc_new;
			default: begin
			end
		endcase
	end

	// Output register: hold the word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			opx_q <= pos_x_q;
			opy_q <= pos_y_q;
			ovx_q <= vel_x_q;
			ovy_q <= vel_y_q;
			ohd_q <= head_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_pos_x   = opx_q;
	assign out_pos_y   = opy_q;
	assign out_vel_x   = ovx_q;
	assign out_vel_y   = ovy_q;
	assign out_heading = ohd_q;

	`GBI_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	`GBI_ASSERT_IMP(a_start_when_free, unit_req.start, !unit_rsp.busy)
	`GBI_ASSERT_IMP(a_done_when_waiting, unit_rsp.done, unit_wait)

endmodule
